FILE: src/gradient_noise_2d_macros.svh
// Assertion macros for the gradient noise block.
`ifndef GRADIENT_NOISE_2D_MACROS_SVH
`define GRADIENT_NOISE_2D_MACROS_SVH

`ifndef SYNTH
`define GN2_CHECK(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("gn2 check failed");
`define GN2_CHECK_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("gn2 check failed");
`else
`define GN2_CHECK(label, ante, cons)
`define GN2_CHECK_NEXT(label, ante, cons)
`endif

`endif

FILE: src/gn2_pkg.sv
// Types, constants and arithmetic helpers for the gradient noise block.
package gn2_pkg;

	localparam int PERIOD = 256;
	localparam int IDX_W  = $clog2(PERIOD);
	localparam int CFG_W  = 16;

	typedef enum logic [1:0] {
		REG_FREQUENCY   = 2'd0,
		REG_AMPLITUDE   = 2'd1,
		REG_PERIOD_MASK = 2'd2
	} cfg_reg_t;

	localparam logic FUNC_LOAD = 1'b0;
	localparam logic FUNC_EVAL = 1'b1;

	localparam logic [15:0]      FREQ_RST = 16'd256;
	localparam logic [15:0]      AMPL_RST = 16'd256;
	localparam logic [IDX_W-1:0] MASK_RST = IDX_W'(PERIOD - 1);

	// gradient components, Q1.15
	localparam logic signed [16:0] G_DIAG = 17'sd23170;
	localparam logic signed [16:0] G_AXIS = 17'sd32768;

	function automatic logic signed [16:0] grad_x(input logic [2:0] h);
		logic signed [16:0] g;
		case (h)
			3'd0, 3'd1: g = G_DIAG;
			3'd2, 3'd3: g = -G_DIAG;
			3'd4:       g = G_AXIS;
			3'd6:       g = -G_AXIS;
			default:    g = '0;
		endcase
		return g;
	endfunction

	function automatic logic signed [16:0] grad_y(input logic [2:0] h);
		logic signed [16:0] g;
		case (h)
			3'd0, 3'd2: g = G_DIAG;
			3'd1, 3'd3: g = -G_DIAG;
			3'd5:       g = -G_AXIS;
			3'd7:       g = G_AXIS;
			default:    g = '0;
		endcase
		return g;
	endfunction

	// a*b >> 16 on Q0.16 values
	function automatic logic [15:0] q16_mul(input logic [15:0] a, input logic [15:0] b);
		logic [31:0] p;
		p = 32'(a) * 32'(b);
		return p[31:16];
	endfunction

	// 10 - (15 - 6t)*t, Q.16
	function automatic logic [19:0] fade_inner(input logic [15:0] t);
		logic [19:0] k;
		logic [35:0] p;
		k = 20'd983040 - 20'(t) * 20'd6;
		p = 36'(k) * 36'(t);
		return 20'd655360 - p[35:16];
	endfunction

	// t^3 * inner, clamped to one
	function automatic logic [16:0] fade_final(input logic [15:0] t3, input logic [19:0] inner);
		logic [35:0] p;
		p = 36'(t3) * 36'(inner);
		return (p[35:16] > 20'd65536) ? 17'd65536 : p[32:16];
	endfunction

endpackage

FILE: src/gn2_ram.sv
// Generic RAM: one write port, two registered read ports.
module gn2_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr_a,
	input  logic [$clog2(DEPTH)-1:0] raddr_b,
	output logic [WIDTH-1:0]         rdata_a,
	output logic [WIDTH-1:0]         rdata_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];
	logic [WIDTH-1:0] rdata_a_q;
	logic [WIDTH-1:0] rdata_b_q;

	// read returns the old word on a same-cycle write
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata_a_q <= mem_q[raddr_a];
		rdata_b_q <= mem_q[raddr_b];
	end

	assign rdata_a = rdata_a_q;
	assign rdata_b = rdata_b_q;

endmodule

FILE: src/gradient_noise_2d.sv
// Top level: pipelined 2-D gradient noise with loadable permutation table.
// A request passes through the stage registers and then the output register;
// its result is then on the ports, with done high.
// Throughput: one request per cycle, loads and evaluations mixed; busy stays low.
// Reset clears pipeline valid bits and sets the config registers; the
// permutation table is not cleared and must be loaded before evaluation.
`include "gradient_noise_2d_macros.svh"

module gradient_noise_2d import gn2_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic               func,
	input  logic [7:0]         table_index,
	input  logic [7:0]         table_value,
	input  logic [31:0]        coord_x,
	input  logic [31:0]        coord_y,
	input  logic               cfg_write,
	input  logic [1:0]         cfg_index,
	input  logic [CFG_W-1:0]   cfg_data,
	output logic               done,
	output logic signed [23:0] noise_value,
	output logic               is_noise
);

	logic [15:0]      frequency_q;
	logic [15:0]      amplitude_q;
	logic [IDX_W-1:0] period_mask_q;

	logic accept;
	assign accept = start && !busy;
	assign busy   = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			frequency_q   <= FREQ_RST;
			amplitude_q   <= AMPL_RST;
			period_mask_q <= MASK_RST;
		end else if (cfg_write) begin
			case (cfg_reg_t'(cfg_index))
				REG_FREQUENCY:   frequency_q   <= cfg_data;
				REG_AMPLITUDE:   amplitude_q   <= cfg_data;
				REG_PERIOD_MASK: period_mask_q <= cfg_data[IDX_W-1:0];
				default: ;
			endcase
		end
	end

	// control pipeline
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5;
	logic valid_s6, valid_s7, valid_s8, valid_s9, valid_s10;
	logic eval_s1, eval_s2, eval_s3, eval_s4, eval_s5;
	logic eval_s6, eval_s7, eval_s8, eval_s9, eval_s10;
	logic done_q, is_noise_q;
	logic signed [23:0] noise_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0; valid_s2 <= 1'b0; valid_s3 <= 1'b0; valid_s4 <= 1'b0;
			valid_s5 <= 1'b0; valid_s6 <= 1'b0; valid_s7 <= 1'b0; valid_s8 <= 1'b0;
			valid_s9 <= 1'b0; valid_s10 <= 1'b0;
			done_q   <= 1'b0;
		end else begin
			valid_s1 <= accept;   valid_s2 <= valid_s1; valid_s3 <= valid_s2;
			valid_s4 <= valid_s3; valid_s5 <= valid_s4; valid_s6 <= valid_s5;
			valid_s7 <= valid_s6; valid_s8 <= valid_s7; valid_s9 <= valid_s8;
			valid_s10 <= valid_s9;
			done_q   <= valid_s10;
		end
	end

	// ---- stage 1: scaled coordinates ----
	logic [47:0] mul_x, mul_y;
	assign mul_x = 48'(coord_x) * 48'(frequency_q);
	assign mul_y = 48'(coord_y) * 48'(frequency_q);

	logic [23:0] pos_x_s1, pos_y_s1;
	logic [7:0]  tidx_s1, tval_s1;

	// ---- stage 2 ----
	logic [7:0]  tidx_s2, tval_s2, idx_y_s2;
	logic [15:0] fx_s2, fy_s2, t2x_s2, t2y_s2;
	logic [19:0] inx_s2, iny_s2;
	logic        byp0_s2, byp1_s2;
	logic [7:0]  bval_s2;

	logic [IDX_W-1:0] idx_x_c, idx_y_c, raddr0, raddr1;
	logic [15:0]      fx_c, fy_c;
	logic             byp0_c, byp1_c;
	logic [7:0]       perm0, perm1;

	assign idx_x_c = pos_x_s1[23:16] & period_mask_q;
	assign idx_y_c = pos_y_s1[23:16] & period_mask_q;
	assign fx_c    = pos_x_s1[15:0];
	assign fy_c    = pos_y_s1[15:0];
	assign raddr0  = idx_x_c;
	assign raddr1  = (idx_x_c + IDX_W'(1)) & period_mask_q;
	// a load one stage ahead writes at this same edge: forward it
	assign byp0_c  = valid_s2 && !eval_s2 && (tidx_s2 == raddr0);
	assign byp1_c  = valid_s2 && !eval_s2 && (tidx_s2 == raddr1);

	// ---- stage 3 ----
	logic [15:0] fx_s3, fy_s3, t3x_s3, t3y_s3;
	logic [19:0] inx_s3, iny_s3;
	logic [7:0]  h_aa, h_ab, h_ba, h_bb;

	logic [7:0]       p0_c, p1_c;
	logic [8:0]       sum_a, sum_b;
	logic [IDX_W-1:0] ra0, ra1, rb0, rb1;
	logic             tbl_we;

	assign p0_c   = byp0_s2 ? bval_s2 : perm0;
	assign p1_c   = byp1_s2 ? bval_s2 : perm1;
	assign sum_a  = 9'(p0_c) + 9'(idx_y_s2);
	assign sum_b  = 9'(p1_c) + 9'(idx_y_s2);
	assign ra0    = sum_a[7:0] & period_mask_q;
	assign ra1    = (sum_a[7:0] + 8'd1) & period_mask_q;
	assign rb0    = sum_b[7:0] & period_mask_q;
	assign rb1    = (sum_b[7:0] + 8'd1) & period_mask_q;
	// table write lands after the last read of every older request
	assign tbl_we = valid_s2 && !eval_s2;

	gn2_ram #(.WIDTH(8), .DEPTH(PERIOD)) u_ram_x (
		.clk(clk), .we(tbl_we), .waddr(tidx_s2), .wdata(tval_s2),
		.raddr_a(raddr0), .raddr_b(raddr1), .rdata_a(perm0), .rdata_b(perm1)
	);
	gn2_ram #(.WIDTH(8), .DEPTH(PERIOD)) u_ram_a (
		.clk(clk), .we(tbl_we), .waddr(tidx_s2), .wdata(tval_s2),
		.raddr_a(ra0), .raddr_b(ra1), .rdata_a(h_aa), .rdata_b(h_ab)
	);
	gn2_ram #(.WIDTH(8), .DEPTH(PERIOD)) u_ram_b (
		.clk(clk), .we(tbl_we), .waddr(tidx_s2), .wdata(tval_s2),
		.raddr_a(rb0), .raddr_b(rb1), .rdata_a(h_ba), .rdata_b(h_bb)
	);

	// ---- stage 4: fade weights and gradient products ----
	logic [16:0]        wx_s4, wy_s4;
	logic signed [33:0] pxaa_s4, pyaa_s4, pxba_s4, pyba_s4;
	logic signed [33:0] pxab_s4, pyab_s4, pxbb_s4, pybb_s4;

	logic signed [16:0] ox0, ox1, oy0, oy1;
	assign ox0 = $signed({1'b0, fx_s3});
	assign ox1 = $signed({1'b1, fx_s3});	// fx - 1.0
	assign oy0 = $signed({1'b0, fy_s3});
	assign oy1 = $signed({1'b1, fy_s3});

	// ---- stage 5: corner dot products ----
	logic signed [17:0] daa_s5, dba_s5, dab_s5, dbb_s5;
	logic [16:0]        wx_s5, wy_s5;

	function automatic logic signed [17:0] dot_round(input logic signed [33:0] a,
			input logic signed [33:0] b);
		logic signed [34:0] s;
		s = 35'(a) + 35'(b) + 35'sd16384;
		s = s >>> 15;
		return s[17:0];
	endfunction

	// ---- stage 6: x products ----
	logic signed [36:0] plo_s6, phi_s6;
	logic signed [17:0] daa_s6, dab_s6;
	logic [16:0]        wy_s6;

	logic signed [18:0] dlo_c, dhi_c;
	logic signed [17:0] wx_sg;
	assign dlo_c = 19'(dba_s5) - 19'(daa_s5);
	assign dhi_c = 19'(dbb_s5) - 19'(dab_s5);
	assign wx_sg = $signed({1'b0, wx_s5});

	// ---- stage 7: x blends ----
	logic signed [19:0] low_s7, high_s7;
	logic [16:0]        wy_s7;

	function automatic logic signed [19:0] blend_fin(input logic signed [17:0] a,
			input logic signed [36:0] p);
		logic signed [37:0] r;
		r = 38'(p) + 38'sd32768;
		r = r >>> 16;
		return 20'(a) + r[19:0];
	endfunction

	// ---- stage 8: y product ----
	logic signed [38:0] pv_s8;
	logic signed [19:0] low_s8;
	logic signed [20:0] dv_c;
	assign dv_c = 21'(high_s7) - 21'(low_s7);

	// ---- stage 9: y blend ----
	logic signed [20:0] v_s9;
	logic signed [39:0] rv_c;
	assign rv_c = (40'(pv_s8) + 40'sd32768) >>> 16;

	// ---- stage 10: amplitude ----
	logic signed [37:0] m_s10;

	// ---- output: round and saturate ----
	logic signed [38:0] r_c;
	logic signed [23:0] sat_c;
	assign r_c = (39'(m_s10) + 39'sd256) >>> 9;
	always_comb begin
		if (r_c > 39'sd8388607) begin
			sat_c = 24'sh7FFFFF;
		end else if (r_c < -39'sd8388608) begin
			sat_c = 24'sh800000;
		end else begin
			sat_c = r_c[23:0];
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		eval_s1  <= (func == FUNC_EVAL);
		pos_x_s1 <= mul_x[31:8];
		pos_y_s1 <= mul_y[31:8];
		tidx_s1  <= table_index;
		tval_s1  <= table_value;

		eval_s2  <= eval_s1;
		tidx_s2  <= tidx_s1;
		tval_s2  <= tval_s1;
		idx_y_s2 <= idx_y_c;
		fx_s2    <= fx_c;
		fy_s2    <= fy_c;
		t2x_s2   <= q16_mul(fx_c, fx_c);
		t2y_s2   <= q16_mul(fy_c, fy_c);
		inx_s2   <= fade_inner(fx_c);
		iny_s2   <= fade_inner(fy_c);
		byp0_s2  <= byp0_c;
		byp1_s2  <= byp1_c;
		bval_s2  <= tval_s2;

		eval_s3  <= eval_s2;
		fx_s3    <= fx_s2;
		fy_s3    <= fy_s2;
		t3x_s3   <= q16_mul(t2x_s2, fx_s2);
		t3y_s3   <= q16_mul(t2y_s2, fy_s2);
		inx_s3   <= inx_s2;
		iny_s3   <= iny_s2;

		eval_s4  <= eval_s3;
		wx_s4    <= fade_final(t3x_s3, inx_s3);
		wy_s4    <= fade_final(t3y_s3, iny_s3);
		pxaa_s4  <= grad_x(h_aa[2:0]) * ox0;
		pyaa_s4  <= grad_y(h_aa[2:0]) * oy0;
		pxba_s4  <= grad_x(h_ba[2:0]) * ox1;
		pyba_s4  <= grad_y(h_ba[2:0]) * oy0;
		pxab_s4  <= grad_x(h_ab[2:0]) * ox0;
		pyab_s4  <= grad_y(h_ab[2:0]) * oy1;
		pxbb_s4  <= grad_x(h_bb[2:0]) * ox1;
		pybb_s4  <= grad_y(h_bb[2:0]) * oy1;

		eval_s5  <= eval_s4;
		daa_s5   <= dot_round(pxaa_s4, pyaa_s4);
		dba_s5   <= dot_round(pxba_s4, pyba_s4);
		dab_s5   <= dot_round(pxab_s4, pyab_s4);
		dbb_s5   <= dot_round(pxbb_s4, pybb_s4);
		wx_s5    <= wx_s4;
		wy_s5    <= wy_s4;

		eval_s6  <= eval_s5;
		plo_s6   <= 37'(dlo_c) * 37'(wx_sg);
		phi_s6   <= 37'(dhi_c) * 37'(wx_sg);
		daa_s6   <= daa_s5;
		dab_s6   <= dab_s5;
		wy_s6    <= wy_s5;

		eval_s7  <= eval_s6;
		low_s7   <= blend_fin(daa_s6, plo_s6);
		high_s7  <= blend_fin(dab_s6, phi_s6);
		wy_s7    <= wy_s6;

		eval_s8  <= eval_s7;
		pv_s8    <= 39'(dv_c) * 39'($signed({1'b0, wy_s7}));
		low_s8   <= low_s7;

		eval_s9  <= eval_s8;
		v_s9     <= 21'(low_s8) + rv_c[20:0];

		eval_s10 <= eval_s9;
		m_s10    <= 38'(v_s9) * 38'($signed({1'b0, amplitude_q}));

		is_noise_q <= eval_s10;
		noise_q    <= eval_s10 ? sat_c : '0;
	end

	assign done        = done_q;
	assign is_noise    = is_noise_q;
	assign noise_value = noise_q;

	`GN2_CHECK(a_load_zero, done && !is_noise, noise_value == '0)
	`GN2_CHECK_NEXT(a_out_follows, valid_s10, done && (is_noise == $past(eval_s10)))
	`GN2_CHECK_NEXT(a_no_spurious, !valid_s10, !done)
	`GN2_CHECK(a_bypass_src, byp0_s2 || byp1_s2, valid_s3 && !eval_s3)

endmodule

FILE: test/gradient_noise_2d_tb.sv
// Self-checking testbench for gradient_noise_2d: directed and random requests.
module gradient_noise_2d_tb;
	import gn2_pkg::*;

	localparam int CYCLE_LIMIT = 400000;
	localparam int DRAIN_CYCLES = 16;

	typedef struct {
		logic signed [23:0] noise;
		logic               noise_flag;
	} noise_result_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic               func = FUNC_LOAD;
	logic [7:0]         table_index = '0;
	logic [7:0]         table_value = '0;
	logic [31:0]        coord_x = '0;
	logic [31:0]        coord_y = '0;
	logic               cfg_write = 1'b0;
	logic [1:0]         cfg_index = '0;
	logic [CFG_W-1:0]   cfg_data = '0;
	logic               done;
	logic signed [23:0] noise_value;
	logic               is_noise;

	noise_result_t pending_noise[$];
	logic [7:0]    perm_copy[PERIOD];
	logic [15:0]   freq_q88 = FREQ_RST;
	logic [15:0]   ampl_q88 = AMPL_RST;
	logic [7:0]    mask_q = MASK_RST;
	int            err_count = 0;
	int            cycle_count = 0;
	bit            no_gaps = 1'b0;

	gradient_noise_2d dut (
		.clk(clk), .arst_n(arst_n), .start(start), .busy(busy), .func(func),
		.table_index(table_index), .table_value(table_value),
		.coord_x(coord_x), .coord_y(coord_y),
		.cfg_write(cfg_write), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.done(done), .noise_value(noise_value), .is_noise(is_noise)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	function automatic longint round_rshift(longint v, int s);
		return (v + (longint'(1) << (s - 1))) >>> s;
	endfunction

	function automatic longint fade_q16(longint t);
		longint t2, t3, inner, r;
		t2 = (t * t) >>> 16;
		t3 = (t2 * t) >>> 16;
		inner = 655360 - (((983040 - 6 * t) * t) >>> 16);
		r = (t3 * inner) >>> 16;
		return (r > 65536) ? 65536 : r;
	endfunction

	function automatic longint gradient_dot(logic [7:0] h, longint x, longint y);
		longint gx, gy;
		case (h[2:0])
			3'd0: begin gx = 23170; gy = 23170; end
			3'd1: begin gx = 23170; gy = -23170; end
			3'd2: begin gx = -23170; gy = 23170; end
			3'd3: begin gx = -23170; gy = -23170; end
			3'd4: begin gx = 32768; gy = 0; end
			3'd5: begin gx = 0; gy = -32768; end
			3'd6: begin gx = -32768; gy = 0; end
			default: begin gx = 0; gy = 32768; end
		endcase
		return round_rshift(gx * x + gy * y, 15);
	endfunction

	function automatic longint mix(longint w, longint a, longint b);
		return a + round_rshift((b - a) * w, 16);
	endfunction

	function automatic logic [7:0] perm_at(int unsigned i);
		return perm_copy[(i & mask_q) % PERIOD];
	endfunction

	function automatic logic signed [23:0] predict_noise(logic [31:0] x, logic [31:0] y);
		longint unsigned px, py;
		int unsigned cx, cy, ha, hb;
		longint fx, fy, wx, wy, lo, hi, v, r;
		px = longint'(x) * freq_q88;
		py = longint'(y) * freq_q88;
		cx = int'(px >> 24) & mask_q;
		cy = int'(py >> 24) & mask_q;
		fx = (px >> 8) & 16'hFFFF;
		fy = (py >> 8) & 16'hFFFF;
		ha = perm_at(cx) + cy;
		hb = perm_at(cx + 1) + cy;
		wx = fade_q16(fx);
		wy = fade_q16(fy);
		lo = mix(wx, gradient_dot(perm_at(ha), fx, fy),
			gradient_dot(perm_at(hb), fx - 65536, fy));
		hi = mix(wx, gradient_dot(perm_at(ha + 1), fx, fy - 65536),
			gradient_dot(perm_at(hb + 1), fx - 65536, fy - 65536));
		v = mix(wy, lo, hi);
		r = round_rshift(v * ampl_q88, 9);
		if (r > 8388607) r = 8388607;
		if (r < -8388608) r = -8388608;
		return r[23:0];
	endfunction

	// result checker; done marks a one-cycle result
	always @(posedge clk) begin
		noise_result_t e;
		if (arst_n && done) begin
			if (pending_noise.size() == 0) begin
				$error("unexpected result noise_value=%0d is_noise=%0b", noise_value, is_noise);
				err_count++;
			end else begin
				e = pending_noise.pop_front();
				if (noise_value !== e.noise) begin
					$error("noise_value expected %0d actual %0d", e.noise, noise_value);
					err_count++;
				end
				if (is_noise !== e.noise_flag) begin
					$error("is_noise expected %0b actual %0b", e.noise_flag, is_noise);
					err_count++;
				end
			end
		end
	end

	// leaves start high; a gap or bus_idle lowers it
	task automatic send_request(logic f, logic [7:0] ti, logic [7:0] tv,
			logic [31:0] x, logic [31:0] y);
		int gap;
		noise_result_t e;
		gap = no_gaps ? 0 : $urandom_range(0, 10);
		if (gap > 0) begin
			start <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		start <= 1'b1;
		func <= f;
		table_index <= ti;
		table_value <= tv;
		coord_x <= x;
		coord_y <= y;
		do @(posedge clk); while (busy);
		if (f == FUNC_LOAD) begin
			perm_copy[ti] = tv;
			e.noise = '0;
			e.noise_flag = 1'b0;
		end else begin
			e.noise = predict_noise(x, y);
			e.noise_flag = 1'b1;
		end
		pending_noise.push_back(e);
	endtask

	task automatic bus_idle();
		start <= 1'b0;
		while (pending_noise.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
	endtask

	task automatic write_reg(cfg_reg_t r, logic [CFG_W-1:0] d);
		cfg_write <= 1'b1;
		cfg_index <= r;
		cfg_data <= d;
		@(posedge clk);
		cfg_write <= 1'b0;
		case (r)
			REG_FREQUENCY: freq_q88 = d;
			REG_AMPLITUDE: ampl_q88 = d;
			default: mask_q = d[7:0];
		endcase
		@(posedge clk);
	endtask

	task automatic test_table_load();
		for (int i = 0; i < PERIOD; i++)
			send_request(FUNC_LOAD, i[7:0], 8'($urandom), '0, '0);
		bus_idle();
	endtask

	task automatic test_directed();
		send_request(FUNC_EVAL, '0, '0, 32'h0, 32'h0);
		send_request(FUNC_EVAL, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(FUNC_EVAL, '0, '0, 32'h0000_8000, 32'h0001_4000);
		send_request(FUNC_EVAL, '0, '0, 32'h0000_FFFF, 32'h0000_0001);
		send_request(FUNC_EVAL, '0, '0, 32'hFFFF_0000, 32'h0000_FFFF);
		send_request(FUNC_LOAD, 8'hFF, 8'hFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(FUNC_LOAD, 8'h00, 8'h00, '0, '0);
		bus_idle();
		write_reg(REG_AMPLITUDE, 16'hFFFF); // maximum amplitude
		write_reg(REG_FREQUENCY, 16'hFFFF);
		send_request(FUNC_EVAL, '0, '0, 32'h0000_4000, 32'h0000_C000);
		send_request(FUNC_EVAL, '0, '0, 32'hFFFF_FFFF, 32'h0000_0000);
		send_request(FUNC_EVAL, '0, '0, 32'h1234_5678, 32'h8765_4321);
		bus_idle();
		write_reg(REG_FREQUENCY, 16'h0000);
		write_reg(REG_PERIOD_MASK, 16'h0000);
		write_reg(REG_AMPLITUDE, 16'h0000);
		send_request(FUNC_EVAL, '0, '0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		send_request(FUNC_EVAL, '0, '0, 32'h0003_8000, 32'h0001_0000);
		bus_idle();
		write_reg(REG_FREQUENCY, 16'h0100);
		write_reg(REG_AMPLITUDE, 16'h0100);
		write_reg(REG_PERIOD_MASK, 16'h00A5); // not 2^n-1
		send_request(FUNC_EVAL, '0, '0, 32'h00FF_8000, 32'h00A5_2000);
		send_request(FUNC_EVAL, '0, '0, 32'h0100_0000, 32'h0000_0000);
		bus_idle();
	endtask

	task automatic test_random(logic [15:0] fr, logic [15:0] am, logic [7:0] mk, int n);
		logic [31:0] x, y;
		write_reg(REG_FREQUENCY, fr);
		write_reg(REG_AMPLITUDE, am);
		write_reg(REG_PERIOD_MASK, {8'h00, mk});
		for (int i = 0; i < n; i++) begin
			if (i % 50 == 0) no_gaps = ($urandom_range(0, 3) == 0);
			x = $urandom();
			y = $urandom();
			if ($urandom_range(0, 1)) begin
				x = x & 32'h003F_FFFF;
				y = y & 32'h003F_FFFF;
			end
			if ($urandom_range(0, 9) == 0)
				send_request(FUNC_LOAD, 8'($urandom), 8'($urandom), x, y);
			else
				send_request(FUNC_EVAL, 8'($urandom), 8'($urandom), x, y);
		end
		no_gaps = 1'b0;
		bus_idle();
	endtask

	initial begin
		repeat (2) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_table_load();
		test_directed();
		test_random(16'h0100, 16'h0100, 8'hFF, 300);
		test_random(16'hFFFF, 16'hFFFF, 8'h0F, 250);
		test_random(16'($urandom), 16'($urandom), 8'h3F, 300);
		test_random(16'h0001, 16'h8000, 8'h00, 150);
		test_random(16'($urandom), 16'h0300, 8'h5A, 130);
		if (err_count == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end
endmodule

FILE: sim.f
+incdir+src
src/gn2_pkg.sv
src/gn2_ram.sv
src/gradient_noise_2d.sv
test/gradient_noise_2d_tb.sv
